@@ rtl/tksrt_pkg.sv @@
// ============================================================================
// tksrt_pkg - shared types and constants of the top-k sorted record table
// Field widths, opcodes, default sizes and the record type held by each cell.
// ============================================================================
`default_nettype none

package tksrt_pkg;

    localparam int DEPTH_DEF      = 8;
    localparam int LANG_COUNT_DEF = 3;

    localparam int AMOUNT_W      = 24;
    localparam int TS_W          = 32;
    localparam int LANG_W        = 2;
    localparam int LEVEL_W       = 4;
    localparam int READ_IDX_W    = 3;
    localparam int RANK_W        = 3;
    localparam int ENTRY_COUNT_W = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic [AMOUNT_W-1:0] amount;
        logic [TS_W-1:0]     timestamp;
        logic [LANG_W-1:0]   language;
        logic [LEVEL_W-1:0]  level;
    } rec_t;

    // insert command broadcast to every cell
    typedef struct packed {
        logic en;
        rec_t rec;
    } ins_t;

endpackage : tksrt_pkg

`default_nettype wire

@@ rtl/tksrt_cell.sv @@
// ============================================================================
// tksrt_cell - one slot of the sorted table
// Holds one record; on insert it keeps, takes the new record, or shifts in
// its left neighbor's record.
// ============================================================================
`default_nettype none

module tksrt_cell
    import tksrt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire ins_t ins,
    input  wire rec_t left_rec,
    input  wire logic left_valid,
    input  wire logic left_keep,
    output rec_t      rec,
    output logic      valid,
    output logic      keep,
    output logic      take_new
);

    rec_t rec_reg;
    rec_t rec_next;
    logic valid_reg;
    logic valid_next;

    // entry stays put when it ranks at or above the new amount
    assign keep     = valid_reg && (rec_reg.amount >= ins.rec.amount);
    assign take_new = ins.en && !keep && left_keep;

    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (ins.en && !keep)
        begin
            rec_next   = left_keep ? ins.rec : left_rec;
            valid_next = valid_reg | left_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;

endmodule : tksrt_cell

`default_nettype wire

@@ rtl/top_k_sorted_record_table.sv @@
// ============================================================================
// top_k_sorted_record_table - top-k table of records sorted by amount
// A row of compare-and-shift cells keeps up to DEPTH records, highest amount
// first; an insert places a record and a read returns one slot.
// ============================================================================
//
//   channel | handshake                 | payload
//   --------+---------------------------+--------------------------------------
//   in      | in_valid / in_stall       | opcode amount timestamp language
//           |                           | reached_level read_index
//   out     | out_valid / out_stall     | accepted rank entry_count read_valid
//           |                           | read_amount read_timestamp
//           |                           | read_language read_level
//
// Cycles: one transfer per clock unless stalled. Every cell compares its
//   amount with the incoming one in parallel, so an insert settles in the same
//   cycle it is taken; its result is in the output register in the next cycle.
// Reset: clears the cell valid bits, the count and out_valid; record
//   contents are left as they are and are never read before being written.
// Stalls: a single output register; in_stall is raised while a result sits
//   in it and out_stall is high, so the next item waits until it drains.
// ============================================================================
`default_nettype none

module top_k_sorted_record_table
    import tksrt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int LANG_COUNT = LANG_COUNT_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     opcode,
    input  wire logic [AMOUNT_W-1:0]      amount,
    input  wire logic [TS_W-1:0]          timestamp,
    input  wire logic [LANG_W-1:0]        language,
    input  wire logic [LEVEL_W-1:0]       reached_level,
    input  wire logic [READ_IDX_W-1:0]    read_index,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          accepted,
    output logic [RANK_W-1:0]             rank,
    output logic [ENTRY_COUNT_W-1:0]      entry_count,
    output logic                          read_valid,
    output logic [AMOUNT_W-1:0]           read_amount,
    output logic [TS_W-1:0]               read_timestamp,
    output logic [LANG_W-1:0]             read_language,
    output logic [LEVEL_W-1:0]            read_level
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // handshake and count
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_xfer;

    // result payload registers
    logic                     accepted_reg;
    logic [RANK_W-1:0]        rank_reg;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic                     read_valid_reg;
    rec_t                     read_rec_reg;
    logic                     accepted_next;
    logic [RANK_W-1:0]        rank_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_next;
    logic                     read_valid_next;
    rec_t                     read_rec_next;

    // cell row
    ins_t             ins;
    rec_t             cell_rec   [DEPTH];
    logic             cell_valid [DEPTH];
    logic             cell_keep  [DEPTH];
    logic [DEPTH-1:0] take_new;
    rec_t             left_rec   [DEPTH];
    logic             left_valid [DEPTH];
    logic             left_keep  [DEPTH];

    logic             any_take;
    logic [IDX_W-1:0] ins_pos;
    logic             rd_hit;
    rec_t             rd_rec;

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    // Insert command: zero amounts never enter, out-of-range tags fold to 0.
    always_comb
    begin
        ins.en               = in_xfer && (opcode == OP_INSERT) && (amount != '0);
        ins.rec.amount       = amount;
        ins.rec.timestamp    = timestamp;
        ins.rec.language     = (32'(language) >= 32'(LANG_COUNT)) ? '0 : language;
        ins.rec.level        = reached_level;
    end

    // Cell 0 sees a virtual "always keep" neighbor so the new record lands
    // there when every stored amount is lower.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign left_rec[g]   = ins.rec;
            assign left_valid[g] = 1'b1;
            assign left_keep[g]  = 1'b1;
        end
        else
        begin : g_body
            assign left_rec[g]   = cell_rec[g-1];
            assign left_valid[g] = cell_valid[g-1];
            assign left_keep[g]  = cell_keep[g-1];
        end

        tksrt_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ins        (ins),
            .left_rec   (left_rec[g]),
            .left_valid (left_valid[g]),
            .left_keep  (left_keep[g]),
            .rec        (cell_rec[g]),
            .valid      (cell_valid[g]),
            .keep       (cell_keep[g]),
            .take_new   (take_new[g])
        );
    end

    // At most one cell takes the new record; its index is the rank.
    // No taker on a full table means the insert was rejected.
    always_comb
    begin
        any_take = |take_new;
        ins_pos  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (take_new[i])
            begin
                ins_pos = ins_pos | IDX_W'(i);
            end
        end
    end

    // read port: slot select from the row
    always_comb
    begin
        rd_hit = (32'(read_index) < 32'(count_reg));
        rd_rec = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (32'(read_index) == 32'(i))
            begin
                rd_rec = cell_rec[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (any_take && (count_reg != CNT_W'(DEPTH)))
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        accepted_next    = any_take;
        rank_next        = any_take ? RANK_W'(ins_pos) : '0;
        entry_count_next = ENTRY_COUNT_W'(count_next);
        read_valid_next  = 1'b0;
        read_rec_next    = '0;
        if ((opcode == OP_READ) && rd_hit)
        begin
            read_valid_next = 1'b1;
            read_rec_next   = rd_rec;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            accepted_reg    <= accepted_next;
            rank_reg        <= rank_next;
            entry_count_reg <= entry_count_next;
            read_valid_reg  <= read_valid_next;
            read_rec_reg    <= read_rec_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = accepted_reg;
    assign rank           = rank_reg;
    assign entry_count    = entry_count_reg;
    assign read_valid     = read_valid_reg;
    assign read_amount    = read_rec_reg.amount;
    assign read_timestamp = read_rec_reg.timestamp;
    assign read_language  = read_rec_reg.language;
    assign read_level     = read_rec_reg.level;

endmodule : top_k_sorted_record_table

`default_nettype wire

@@ test/top_k_sorted_record_table_tb.sv @@
// ============================================================================
// top_k_sorted_record_table_tb - self-checking bench for the top-k record table
// Drives inserts and reads through the valid/stall input channel and keeps a
// sorted shadow table that predicts every result. Each result is compared
// field by field as it is transferred. Random gaps on the sender, random
// stalls on the receiver and one long output hold exercise back-pressure.
// ============================================================================
`timescale 1ns / 1ps

module top_k_sorted_record_table_tb;

    import tksrt_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int LANG_COUNT  = LANG_COUNT_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 20;
    localparam int LIMIT       = 500000;

    typedef struct packed {
        logic                     accepted;
        logic [RANK_W-1:0]        rank;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     read_valid;
        rec_t                     rd;
    } outcome_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     opcode = OP_INSERT;
    logic [AMOUNT_W-1:0]      amount = '0;
    logic [TS_W-1:0]          timestamp = '0;
    logic [LANG_W-1:0]        language = '0;
    logic [LEVEL_W-1:0]       reached_level = '0;
    logic [READ_IDX_W-1:0]    read_index = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     accepted;
    logic [RANK_W-1:0]        rank;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     read_valid;
    logic [AMOUNT_W-1:0]      read_amount;
    logic [TS_W-1:0]          read_timestamp;
    logic [LANG_W-1:0]        read_language;
    logic [LEVEL_W-1:0]       read_level;

    // shadow of the table: sorted records, highest amount first
    rec_t     board [DEPTH];
    int       board_count = 0;
    outcome_t pending_outcomes [$];

    int  errors = 0;
    int  cycles = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;
    bit  hold_req = 1'b0;

    top_k_sorted_record_table i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .amount         (amount),
        .timestamp      (timestamp),
        .language       (language),
        .reached_level  (reached_level),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .rank           (rank),
        .entry_count    (entry_count),
        .read_valid     (read_valid),
        .read_amount    (read_amount),
        .read_timestamp (read_timestamp),
        .read_language  (read_language),
        .read_level     (read_level)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch on %s at cycle %0d: got %0h, want %0h",
                 field, cycles, got, want);
        errors++;
    endtask

    // Applies one transfer to the shadow table and queues the result it owes.
    task automatic board_apply(input logic op, input logic [AMOUNT_W-1:0] amt,
                               input logic [TS_W-1:0] ts,
                               input logic [LANG_W-1:0] lang,
                               input logic [LEVEL_W-1:0] lvl,
                               input logic [READ_IDX_W-1:0] idx);
        outcome_t res;
        int       kept;
        int       pos;
        bit       take;
        res  = '0;
        kept = 0;
        pos  = 0;
        take = 1'b0;
        if (op == OP_INSERT)
        begin
            if (amt != '0)
            begin
                if (board_count < DEPTH)
                begin
                    kept = board_count;
                    take = 1'b1;
                end
                else if (amt > board[DEPTH-1].amount)
                begin
                    // full: the last entry falls off
                    kept = DEPTH - 1;
                    take = 1'b1;
                end
                if (take)
                begin
                    // equal amounts keep arrival order
                    while (pos < kept && board[pos].amount >= amt)
                        pos++;
                    for (int i = kept; i > pos; i--)
                        board[i] = board[i-1];
                    board[pos].amount    = amt;
                    board[pos].timestamp = ts;
                    board[pos].language  = (int'(lang) >= LANG_COUNT) ? '0 : lang;
                    board[pos].level     = lvl;
                    board_count  = kept + 1;
                    res.accepted = 1'b1;
                    res.rank     = RANK_W'(pos);
                end
            end
        end
        else if (int'(idx) < board_count)
        begin
            res.read_valid = 1'b1;
            res.rd         = board[idx];
        end
        res.entry_count = ENTRY_COUNT_W'(board_count);
        pending_outcomes.push_back(res);
    endtask

    // Prediction and checking share one process so a transfer is always
    // predicted before any result it causes is compared.
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board_apply(opcode, amount, timestamp, language, reached_level,
                            read_index);
            if (out_valid && !out_stall)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("unexpected result", 64'd1, 64'd0);
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (accepted !== want.accepted)
                        report_mismatch("accepted", 64'(accepted),
                                        64'(want.accepted));
                    if (rank !== want.rank)
                        report_mismatch("rank", 64'(rank), 64'(want.rank));
                    if (entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(entry_count),
                                        64'(want.entry_count));
                    if (read_valid !== want.read_valid)
                        report_mismatch("read_valid", 64'(read_valid),
                                        64'(want.read_valid));
                    if (read_amount !== want.rd.amount)
                        report_mismatch("read_amount", 64'(read_amount),
                                        64'(want.rd.amount));
                    if (read_timestamp !== want.rd.timestamp)
                        report_mismatch("read_timestamp", 64'(read_timestamp),
                                        64'(want.rd.timestamp));
                    if (read_language !== want.rd.language)
                        report_mismatch("read_language", 64'(read_language),
                                        64'(want.rd.language));
                    if (read_level !== want.rd.level)
                        report_mismatch("read_level", 64'(read_level),
                                        64'(want.rd.level));
                end
            end
        end
    end

    // Receiver side: random stalls, or one long hold when asked for.
    initial
    begin : rx_stall_gen
        int len;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                len = idle_len();
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // One transfer on the input channel; returns in the step it is taken.
    task automatic send_record(input logic op, input logic [AMOUNT_W-1:0] amt,
                               input logic [TS_W-1:0] ts,
                               input logic [LANG_W-1:0] lang,
                               input logic [LEVEL_W-1:0] lvl,
                               input logic [READ_IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 2) == 0)
            gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        amount        <= amt;
        timestamp     <= ts;
        language      <= lang;
        reached_level <= lvl;
        read_index    <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random item, biased toward amounts close to what the table holds so
    // that ties, near misses and inserts at every rank keep happening.
    task automatic send_random_record();
        logic [AMOUNT_W-1:0] amt;
        int                  pick;
        int                  k;
        int                  near;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            amt = '0;
        else if (pick == 1)
            amt = '1;
        else if (pick <= 4 || board_count == 0)
            amt = AMOUNT_W'($urandom());
        else
        begin
            k    = ($urandom_range(0, 1) == 0) ? board_count - 1
                                                : int'($urandom_range(0, board_count - 1));
            near = int'(board[k].amount) + int'($urandom_range(0, 2)) - 1;
            if (near < 0)
                near = 0;
            if (near > 2**AMOUNT_W - 1)
                near = 2**AMOUNT_W - 1;
            amt = AMOUNT_W'(near);
        end
        send_record(($urandom_range(0, 9) < 3) ? OP_READ : OP_INSERT, amt,
                    $urandom(), LANG_W'($urandom_range(0, 3)),
                    LEVEL_W'($urandom_range(0, 15)),
                    READ_IDX_W'($urandom_range(0, 7)));
    endtask

    task automatic test_empty_reads();
        send_record(OP_READ, '0, '0, 2'd0, 4'd0, 3'd0);
        send_record(OP_READ, '1, '1, 2'd3, 4'd15, 3'd7);
    endtask

    task automatic test_extremes();
        send_record(OP_INSERT, '0, '1, 2'd1, 4'd9, 3'd0);        // ignored
        send_record(OP_INSERT, '1, '1, 2'd3, 4'd15, 3'd7);       // language forced
        send_record(OP_INSERT, 24'd1, '0, 2'd0, 4'd0, 3'd0);
        send_record(OP_READ, '0, '0, 2'd0, 4'd0, 3'd5);          // past the count
        send_record(OP_READ, '0, '0, 2'd0, 4'd0, 3'd0);
    endtask

    task automatic test_equal_amounts();
        send_record(OP_INSERT, 24'd100, $urandom(), 2'd1, 4'd3, 3'd0);
        send_record(OP_INSERT, 24'd100, $urandom(), 2'd2, 4'd5, 3'd0);
        send_record(OP_READ, '0, '0, 2'd0, 4'd0, 3'd1);
        send_record(OP_READ, '0, '0, 2'd0, 4'd0, 3'd2);
    endtask

    task automatic test_full_table();
        send_record(OP_INSERT, 24'd50, $urandom(), 2'd2, 4'd1, 3'd0);
        send_record(OP_INSERT, 24'd200, $urandom(), 2'd1, 4'd2, 3'd0);
        send_record(OP_INSERT, 24'd100, $urandom(), 2'd0, 4'd7, 3'd0);
        send_record(OP_INSERT, 24'd7, $urandom(), 2'd3, 4'd8, 3'd0);
        send_record(OP_INSERT, 24'd1, $urandom(), 2'd1, 4'd4, 3'd0);   // equal to last
        send_record(OP_INSERT, 24'd2, $urandom(), 2'd2, 4'd6, 3'd0);   // drops last
        send_record(OP_INSERT, 24'd2, $urandom(), 2'd1, 4'd6, 3'd0);   // equal again
        send_record(OP_INSERT, '1, $urandom(), 2'd1, 4'd12, 3'd0);     // ties the top
        send_record(OP_READ, '0, '0, 2'd0, 4'd0, 3'd0);
        send_record(OP_READ, '0, '0, 2'd0, 4'd0, 3'd7);
    endtask

    // Receiver holds off while the sender keeps offering back to back, so
    // the output register fills and the input stalls.
    task automatic test_output_hold();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (24) send_random_record();
    endtask

    task automatic test_random_stream(input int n, input bit tx_idle,
                                      input bit rx_idle);
        tx_idle_en = tx_idle;
        rx_idle_en = rx_idle;
        repeat (n) send_random_record();
    endtask

    initial
    begin : run_tests
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_empty_reads();
        test_extremes();
        test_equal_amounts();
        test_full_table();
        test_random_stream(500, 1'b1, 1'b1);
        test_output_hold();
        test_random_stream(300, 1'b0, 1'b0);
        test_random_stream(300, 1'b1, 1'b0);
        test_random_stream(300, 1'b0, 1'b1);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
